// ----- hdl/afla_pkg.sv -----
// ============================================================================
// afla_pkg
// Types and constants shared by the free-list allocator modules.
// ============================================================================
package afla_pkg;

    localparam int IDX_W    = 10;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;
    localparam int CFG_W    = 11;
    localparam int CFG_RESET = 1024;

    localparam logic [CMD_W-1:0] CMD_ALLOC     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE_NODE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE_LIST = 2'd2;
    localparam logic [CMD_W-1:0] CMD_REINIT    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] node_index;
        logic [IDX_W-1:0] tail_index;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]  granted_index;
        logic [STAT_W-1:0] status;
        logic              pool_empty;
    } t_out_word;

endpackage

// ----- hdl/afla_ram.sv -----
// ============================================================================
// afla_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ============================================================================
module afla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/afla_ctrl.sv -----
// ============================================================================
// afla_ctrl
// Command sequencer: head pointer, chain build sweep and result register.
// ============================================================================
module afla_ctrl import afla_pkg::*; #(
    parameter int POOL_DEPTH = 1024,
    localparam int AW = $clog2(POOL_DEPTH),
    localparam int CW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [CW-1:0] i_cap,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_in_word      i_in_word,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_out_word     o_out_word,
    output logic          o_mem_we,
    output logic [AW-1:0] o_mem_waddr,
    output logic [AW:0]   o_mem_wdata,
    output logic [AW-1:0] o_mem_raddr,
    input  logic [AW:0]   i_mem_rdata
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ALLOC = 2'd1;
    localparam logic [1:0] S_BUILD = 2'd2;

    localparam int RST_CAP = (CFG_RESET > POOL_DEPTH) ? POOL_DEPTH : CFG_RESET;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic          r_empty, n_empty;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_bcap, n_bcap;
    logic          r_out_valid, n_out_valid;
    t_out_word     r_out_word, n_out_word;

    logic          w_accept;
    logic          w_node_bad;
    logic          w_tail_bad;
    logic          w_last;
    logic [CW-1:0] w_ptr_ext;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_node_bad = CW'(i_in_word.node_index) >= i_cap;
    assign w_tail_bad = CW'(i_in_word.tail_index) >= i_cap;
    assign w_ptr_ext  = CW'(r_ptr);
    assign w_last     = (r_ptr == AW'(POOL_DEPTH - 1));

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_empty     = r_empty;
        n_ptr       = r_ptr;
        n_bcap      = r_bcap;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_raddr = r_head;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_word.granted_index = '0;
                    n_out_word.status        = ST_OK;
                    n_out_word.pool_empty    = r_empty;
                    case (i_in_word.command)
                        CMD_ALLOC: begin
                            if (r_empty) begin
                                n_out_word.status = ST_EMPTY;
                                n_out_valid       = 1'b1;
                            end else begin
                                n_state = S_ALLOC;
                            end
                        end
                        CMD_FREE_NODE: begin
                            n_out_valid = 1'b1;
                            if (w_node_bad) begin
                                n_out_word.status = ST_RANGE;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = AW'(i_in_word.node_index);
                                o_mem_wdata = {r_empty, r_head};
                                n_head      = AW'(i_in_word.node_index);
                                n_empty     = 1'b0;
                                n_out_word.pool_empty = 1'b0;
                            end
                        end
                        CMD_FREE_LIST: begin
                            n_out_valid = 1'b1;
                            if (w_node_bad || w_tail_bad) begin
                                n_out_word.status = ST_RANGE;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = AW'(i_in_word.tail_index);
                                o_mem_wdata = {r_empty, r_head};
                                n_head      = AW'(i_in_word.node_index);
                                n_empty     = 1'b0;
                                n_out_word.pool_empty = 1'b0;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_head      = '0;
                            n_empty     = 1'b0;
                            n_ptr       = '0;
                            n_bcap      = i_cap;
                            n_state     = S_BUILD;
                            n_out_word.pool_empty = 1'b0;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                n_out_valid              = 1'b1;
                n_out_word.granted_index = IDX_W'(r_head);
                n_out_word.status        = ST_OK;
                n_out_word.pool_empty    = i_mem_rdata[AW];
                if (i_mem_rdata[AW]) begin
                    n_empty = 1'b1;
                    n_head  = '0;
                end else begin
                    n_head = i_mem_rdata[AW-1:0];
                end
                n_state = S_IDLE;
            end
            S_BUILD: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_ptr;
                o_mem_wdata = {(w_ptr_ext >= r_bcap - 1'b1),
                               (w_last ? AW'(0) : r_ptr + 1'b1)};
                if (w_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BUILD;
            r_head      <= '0;
            r_empty     <= 1'b0;
            r_ptr       <= '0;
            r_bcap      <= CW'(RST_CAP);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_empty     <= n_empty;
            r_ptr       <= n_ptr;
            r_bcap      <= n_bcap;
            r_out_valid <= n_out_valid;
        end
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ----- hdl/array_free_list_allocator.sv -----
// ============================================================================
// array_free_list_allocator
// Free-list node allocator over a pool of node slots held in a link RAM.
//
//   channel  direction  handshake                   word
//   in       input      i_in_valid / o_in_ready     t_in_word
//   out      output     o_out_valid / i_out_ready   t_out_word
//   cfg      input      i_cfg_valid / o_cfg_ready   capacity_in_use
//
// free and free-list are answered from the idle state, reinit likewise and
// then starts the build sweep, allocate first waits in S_ALLOC for the
// registered link RAM read of the head; after reset and after reinit the
// chain is rebuilt by a sweep over all POOL_DEPTH entries of the link RAM,
// during which no word is accepted; a word is accepted while the previous
// result is being taken; a stalled result holds the input side off
// ============================================================================
module array_free_list_allocator import afla_pkg::*; #(
    parameter int POOL_DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_word,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

    logic [CFG_W-1:0] r_cap;
    logic [CW-1:0]    w_cap_min;
    logic [CW-1:0]    w_cap;
    logic             w_mem_we;
    logic [AW-1:0]    w_mem_waddr;
    logic [AW:0]      w_mem_wdata;
    logic [AW-1:0]    w_mem_raddr;
    logic [AW:0]      w_mem_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CFG_W'(CFG_RESET);
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // zero acts as one, anything above the pool acts as the pool size
    assign w_cap_min = (r_cap == '0) ? CW'(1) : CW'(r_cap);
    assign w_cap     = (w_cap_min > CW'(POOL_DEPTH)) ? CW'(POOL_DEPTH) : w_cap_min;

    afla_ctrl #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cap       (w_cap),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    afla_ram #(
        .WIDTH (AW + 1),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

endmodule
